@@ hdl/nbgd_pkg.sv @@
// Package for the nearest box distance block: fixed-point constants and CORDIC angle table.
package nbgd_pkg;

  localparam int CORDIC_W     = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_W       = 40;
  localparam int SQRT_STEPS   = 20;
  localparam int MUL_A_W      = 17;
  localparam int MUL_B_W      = 30;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int ACC_W        = 54;

  localparam logic [16:0]         MIN_START   = 17'd100000;
  localparam logic [16:0]         FULL_TURN   = 17'd36000;
  localparam logic [16:0]         HALF_TURN   = 17'd18000;
  localparam logic [16:0]         QUARTER     = 17'd9000;
  localparam logic [MUL_B_W-1:0]  DEG_TO_RAD  = 30'd749613;
  localparam logic [MUL_B_W-1:0]  AREA_K      = 30'd769010935;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 20'sd39797;
  localparam logic signed [CORDIC_W-1:0] ONE_Q16     = 20'sd65536;
  localparam logic signed [CORDIC_W-1:0] HALF_PI     = 20'sd102944;
  localparam logic [SQRT_W-1:0]   SQRT_BIT0   = 40'h40_0000_0000;
  localparam logic [PROD_W-1:0]   ROUND_Q16   = 47'd32768;

  localparam int REG_LON  = 0;
  localparam int REG_LAT  = 1;
  localparam int REG_AREA = 2;

  // arctangent of 2^-i in Q16 radians
  function automatic logic signed [CORDIC_W-1:0] atan_q16(input logic [3:0] i);
    logic signed [CORDIC_W-1:0] v;
    unique case (i)
      4'd0:  v = 20'sd51472;
      4'd1:  v = 20'sd30386;
      4'd2:  v = 20'sd16055;
      4'd3:  v = 20'sd8150;
      4'd4:  v = 20'sd4091;
      4'd5:  v = 20'sd2047;
      4'd6:  v = 20'sd1024;
      4'd7:  v = 20'sd512;
      4'd8:  v = 20'sd256;
      4'd9:  v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/nearest_box_geo_distance.sv @@
// Top level: nearest box great-circle distance with a shared CORDIC, square root and multiplier.
//
//   channel  | signals                                            | direction
//   ---------+----------------------------------------------------+----------
//   in       | in_valid, in_ready, box_lon_left, box_lon_right,   | in
//            | box_lat_down, box_lat_up, last_box                 |
//   out      | out_valid, out_ready, distance_km                  | out
//   cfg      | cfg_we, cfg_index, cfg_data                        | in
//
// Sequence: a box that is not last runs two 16-step rotation passes, two 20-step square
//   roots and one 16-step vectoring pass, all on one shared unit; a last box then adds two
//   multiplier steps, a square root load, a 20-step square root for the area term and the
//   output load, which waits for the output register to be free.
// Reset: rst (synchronous) clears the configuration and control registers to zero and the running minimum to 100000.
// Stalls: a finished result waits in the output register while the next box is taken;
//   only a last box that finds the output register still full holds in the final state.
module nearest_box_geo_distance
  import nbgd_pkg::*;
#(
  parameter int EARTH_RADIUS_KM = 6371
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] box_lon_left,
  input  logic signed [15:0] box_lon_right,
  input  logic signed [14:0] box_lat_down,
  input  logic signed [14:0] box_lat_up,
  input  logic               last_box,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [16:0]        distance_km,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam logic [MUL_B_W-1:0] TWO_R = MUL_B_W'(2 * EARTH_RADIUS_KM);

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_FOLD, S_CONV, S_ZSET, S_ROT, S_CLAMP, S_RNUM,
    S_SQS, S_SQC, S_ATAN, S_DMUL, S_DIST, S_AMLO, S_AMHI, S_AROOT, S_SQT, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic signed [15:0] region_longitude;
  logic signed [14:0] region_latitude;
  logic [23:0]        region_area;

  // captured transaction
  logic signed [15:0] lon_l, lon_r;
  logic signed [14:0] lat_d, lat_u;
  logic               last_q;

  logic [16:0] dx, dy;
  logic        pass;            // low: latitude cosine, high: longitude cosine
  logic [13:0] a_f;
  logic        neg;
  logic signed [17:0] cy, cx;
  logic [16:0] r;
  logic [16:0] s_q;
  logic [16:0] ang;
  logic [16:0] running_min;
  logic [19:0] term;

  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc;

  // shared CORDIC registers
  logic signed [CORDIC_W-1:0] cx_r, cy_r, cz_r;
  logic [3:0] it;

  // shared square root registers
  logic [SQRT_W-1:0] sq_rem, sq_res, sq_bit;
  logic [4:0]        sq_cnt;

  // ---------------- difference of the box edges ----------------
  logic signed [16:0] d_ll, d_lr;
  logic signed [15:0] d_lu, d_ld;
  logic [16:0] a_ll, a_lr, a_lu, a_ld;

  always_comb begin
    d_ll = 17'(lon_l) - 17'(region_longitude);
    d_lr = 17'(lon_r) - 17'(region_longitude);
    d_lu = 16'(lat_u) - 16'(region_latitude);
    d_ld = 16'(lat_d) - 16'(region_latitude);
    a_ll = d_ll[16] ? 17'(-d_ll) : 17'(d_ll);
    a_lr = d_lr[16] ? 17'(-d_lr) : 17'(d_lr);
    a_lu = d_lu[15] ? 17'(-17'(d_lu)) : 17'(d_lu);
    a_ld = d_ld[15] ? 17'(-17'(d_ld)) : 17'(d_ld);
  end

  // ---------------- angle fold to the first quadrant ----------------
  logic [16:0] f_a, f1, f2, f3;
  logic        f_neg;

  always_comb begin
    f_a   = pass ? dx : dy;
    f1    = (f_a >= FULL_TURN) ? f_a - FULL_TURN : f_a;
    f2    = (f1 > HALF_TURN) ? FULL_TURN - f1 : f1;
    f_neg = f2 > QUARTER;
    f3    = f_neg ? HALF_TURN - f2 : f2;
  end

  // ---------------- shared multiplier ----------------
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;

  always_comb begin
    unique case (state)
      S_CONV: begin
        mul_a = {3'b0, a_f};
        mul_b = DEG_TO_RAD;
      end
      S_DMUL: begin
        mul_a = ang;
        mul_b = TWO_R;
      end
      S_AMLO: begin
        mul_a = {5'b0, region_area[11:0]};
        mul_b = AREA_K;
      end
      S_AMHI: begin
        mul_a = {5'b0, region_area[23:12]};
        mul_b = AREA_K;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // ---------------- shared CORDIC step ----------------
  // rotation drives z to zero, vectoring drives y to zero
  logic signed [CORDIC_W-1:0] xs, ys, at, x_n, y_n, z_n;
  logic plus;

  always_comb begin
    xs   = cx_r >>> it;
    ys   = cy_r >>> it;
    at   = atan_q16(it);
    plus = (state == S_ROT) ? cz_r[CORDIC_W-1] : (cy_r > 0);
    if (plus) begin
      x_n = cx_r + ys;
      y_n = cy_r - xs;
      z_n = cz_r + at;
    end else begin
      x_n = cx_r - ys;
      y_n = cy_r + xs;
      z_n = cz_r - at;
    end
  end

  // ---------------- shared square root step ----------------
  logic [SQRT_W:0]   sq_sum;
  logic              sq_ge;
  logic [SQRT_W-1:0] sq_rem_n, sq_res_n;

  always_comb begin
    sq_sum   = {1'b0, sq_res} + {1'b0, sq_bit};
    sq_ge    = {1'b0, sq_rem} >= sq_sum;
    sq_rem_n = sq_ge ? sq_rem - sq_sum[SQRT_W-1:0] : sq_rem;
    sq_res_n = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;
  end

  // ---------------- clamps and output arithmetic ----------------
  logic [16:0] cos_mag;
  logic signed [19:0] num;
  logic [16:0] r_next;
  logic [16:0] ang_next;
  logic [16:0] box_km;
  logic [24:0] mm, diff;
  logic [25:0] rnd;
  logic        out_load;
  logic [PROD_W-1:0] dist_sum;

  always_comb begin
    if (cx_r < 0) cos_mag = '0;
    else if (cx_r > ONE_Q16) cos_mag = 17'd65536;
    else cos_mag = cx_r[16:0];

    num = 20'sd131072 - 20'(cy) - 20'(cx);
    if (num < 0) r_next = '0;
    else if ((num >>> 1) > 20'sd65536) r_next = 17'd65536;
    else r_next = num[17:1];

    if (z_n < 0) ang_next = '0;
    else if (z_n > HALF_PI) ang_next = HALF_PI[16:0];
    else ang_next = z_n[16:0];

    dist_sum = prod + ROUND_Q16;
    box_km   = dist_sum[32:16];

    mm   = {running_min, 8'b0};
    diff = (mm > {5'b0, term}) ? mm - {5'b0, term} : '0;
    rnd  = {1'b0, diff} + 26'd128;

    out_load = (state == S_OUT) && (!out_valid || out_ready);
  end

  assign in_ready = (state == S_IDLE);

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      region_longitude <= '0;
      region_latitude  <= '0;
      region_area      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == 2'(REG_LON)) region_longitude <= cfg_data[15:0];
      if (cfg_index == 2'(REG_LAT)) region_latitude  <= cfg_data[14:0];
      if (cfg_index == 2'(REG_AREA)) region_area     <= cfg_data;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      running_min <= MIN_START;
      pass        <= 1'b0;
      it          <= '0;
      sq_cnt      <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            lon_l  <= box_lon_left;
            lon_r  <= box_lon_right;
            lat_d  <= box_lat_down;
            lat_u  <= box_lat_up;
            last_q <= last_box;
            state  <= S_DIFF;
          end
        end
        S_DIFF: begin
          dx    <= (a_lr < a_ll) ? a_lr : a_ll;
          dy    <= (a_ld < a_lu) ? a_ld : a_lu;
          pass  <= 1'b0;
          state <= S_FOLD;
        end
        S_FOLD: begin
          a_f   <= f3[13:0];
          neg   <= f_neg;
          state <= S_CONV;
        end
        S_CONV: begin
          prod  <= mul_p;
          state <= S_ZSET;
        end
        S_ZSET: begin
          cz_r  <= CORDIC_W'(dist_sum[PROD_W-1:16]);
          cx_r  <= CORDIC_GAIN;
          cy_r  <= '0;
          it    <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          cx_r <= x_n;
          cy_r <= y_n;
          cz_r <= z_n;
          it   <= it + 4'd1;
          if (it == 4'(CORDIC_STEPS - 1)) state <= S_CLAMP;
        end
        S_CLAMP: begin
          if (!pass) begin
            cy    <= neg ? -18'(cos_mag) : 18'(cos_mag);
            pass  <= 1'b1;
            state <= S_FOLD;
          end else begin
            cx    <= neg ? -18'(cos_mag) : 18'(cos_mag);
            state <= S_RNUM;
          end
        end
        S_RNUM: begin
          r      <= r_next;
          sq_rem <= {7'b0, r_next, 16'b0};
          sq_res <= '0;
          sq_bit <= SQRT_BIT0;
          sq_cnt <= '0;
          state  <= S_SQS;
        end
        S_SQS, S_SQC, S_SQT: begin
          if (sq_cnt == 5'(SQRT_STEPS - 1)) begin
            sq_cnt <= '0;
            sq_res <= '0;
            sq_bit <= SQRT_BIT0;
            priority case (state)
              S_SQS: begin
                s_q    <= sq_res_n[16:0];
                sq_rem <= {7'b0, 17'(17'd65536 - r), 16'b0};
                state  <= S_SQC;
              end
              S_SQC: begin
                cx_r  <= CORDIC_W'(sq_res_n[16:0]);
                cy_r  <= CORDIC_W'(s_q);
                cz_r  <= '0;
                it    <= '0;
                state <= S_ATAN;
              end
              default: begin
                term  <= sq_res_n[19:0];
                state <= S_OUT;
              end
            endcase
          end else begin
            sq_rem <= sq_rem_n;
            sq_res <= sq_res_n;
            sq_bit <= sq_bit >> 2;
            sq_cnt <= sq_cnt + 5'd1;
          end
        end
        S_ATAN: begin
          cx_r <= x_n;
          cy_r <= y_n;
          cz_r <= z_n;
          it   <= it + 4'd1;
          if (it == 4'(CORDIC_STEPS - 1)) begin
            ang   <= ang_next;
            state <= S_DMUL;
          end
        end
        S_DMUL: begin
          prod  <= mul_p;
          state <= S_DIST;
        end
        S_DIST: begin
          if (box_km < running_min) running_min <= box_km;
          state <= last_q ? S_AMLO : S_IDLE;
        end
        S_AMLO: begin
          acc   <= ACC_W'(mul_p);
          state <= S_AMHI;
        end
        S_AMHI: begin
          acc   <= acc + (ACC_W'(mul_p) << 12);
          state <= S_AROOT;
        end
        S_AROOT: begin
          sq_rem <= {2'b0, acc[ACC_W-1:16]};
          sq_res <= '0;
          sq_bit <= SQRT_BIT0;
          sq_cnt <= '0;
          state  <= S_SQT;
        end
        S_OUT: begin
          if (out_load) begin
            distance_km <= rnd[24:8];
            running_min <= MIN_START;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_min_bound: assert property (@(posedge clk) disable iff (rst)
    running_min <= MIN_START)
    else $error("running minimum above start value");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after a transaction");

  a_min_restart: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (running_min == MIN_START) && out_valid)
    else $error("minimum not restarted after result load");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !out_ready) |=> state == S_OUT)
    else $error("result overwrote a pending transaction");

endmodule
